FILE: hw/rtl/sttbl_pkg.sv
// ----------------------------------------------------------------------------
// sttbl_pkg
// Shared types and constants of the software timer table.
// ----------------------------------------------------------------------------
package sttbl_pkg;

  localparam int MsPerSec   = 1000;
  localparam int DivCycles  = 5;
  localparam int DivCntW    = 3;

  // ceil(2^38 / 1000): x / 1000 == (x * Recip1000) >> RecipShift for 32-bit x
  localparam logic [31:0] Recip1000  = 32'd274877907;
  localparam int          RecipShift = 38;

  localparam logic [DivCntW-1:0] SC_QUOT  = 3'd0;
  localparam logic [DivCntW-1:0] SC_SPLIT = 3'd1;
  localparam logic [DivCntW-1:0] SC_REM   = 3'd2;
  localparam logic [DivCntW-1:0] SC_RECIP = 3'd3;

  localparam logic REG_TICK_RATE = 1'b0;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_REG   = 2'd1,
    FUNC_UNREG = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_REG   = 2'd0,
    KIND_UNREG = 2'd1,
    KIND_FIRE  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EM_REG_OK     = 3'd0,
    EM_REG_FAIL   = 3'd1,
    EM_UNREG_OK   = 3'd2,
    EM_UNREG_FAIL = 3'd3,
    EM_FIRE       = 3'd4,
    EM_DONE       = 3'd5
  } emit_t;

  typedef struct packed {
    logic  latch;
    logic  tick_inc;
    logic  idx_clr;
    logic  idx_free;
    logic  idx_inc;
    logic  mem_rd;
    logic  mul_start;
    logic  div_step;
    logic  wr_new;
    logic  wr_reload;
    logic  clr_active;
    logic  set_fired;
    logic  out_load;
    emit_t emit_sel;
  } cmd_t;

  typedef struct packed {
    func_t func_in;
    func_t func_q;
    logic  ms_zero;
    logic  tgt_zero;
    logic  full;
    logic  idx_last;
    logic  due;
    logic  match;
    logic  periodic;
    logic  fired;
    logic  div_done;
    logic  out_free;
  } st_t;

endpackage

FILE: hw/rtl/sttbl_if.sv
// ----------------------------------------------------------------------------
// sttbl_if
// Valid/ready channel interfaces for the timer table items and results.
// ----------------------------------------------------------------------------
interface sttbl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] span_ms;
  logic        periodic;
  logic [31:0] target_id;

  modport source (output valid, func, span_ms, periodic, target_id, input ready);
  modport sink (input valid, func, span_ms, periodic, target_id, output ready);
endinterface

interface sttbl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] timer_ident;
  logic [3:0]  slot_index;
  logic        success;
  logic [4:0]  live_count;
  logic [63:0] tick_now;
  logic        last;

  modport source (output valid, kind, timer_ident, slot_index, success, live_count,
                  tick_now, last, input ready);
  modport sink (input valid, kind, timer_ident, slot_index, success, live_count,
                tick_now, last, output ready);
endinterface

FILE: hw/rtl/sttbl_ctrl.sv
// ----------------------------------------------------------------------------
// sttbl_ctrl
// Sequencer for tick scans, timer registration and cancellation.
// ----------------------------------------------------------------------------
module sttbl_ctrl
  import sttbl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  st_t  st,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_MUL       = 13'b0000000000010,
    S_DIV       = 13'b0000000000100,
    S_WR_NEW    = 13'b0000000001000,
    S_WR_RELOAD = 13'b0000000010000,
    S_REPLY     = 13'b0000000100000,
    S_T_RD      = 13'b0000001000000,
    S_T_EV      = 13'b0000010000000,
    S_U_RD      = 13'b0000100000000,
    S_U_EV      = 13'b0001000000000,
    S_E_SCAN    = 13'b0010000000000,
    S_E_OUT     = 13'b0100000000000,
    S_E_DONE    = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  emit_t  rsel, rsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsel  <= EM_REG_FAIL;
    end else begin
      state <= state_next;
      rsel  <= rsel_next;
    end
  end

  always_comb begin
    state_next = state;
    rsel_next  = rsel;
    cmd        = '0;
    cmd.emit_sel = rsel;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (st.func_in)
            FUNC_TICK: begin
              cmd.tick_inc = 1'b1;
              cmd.idx_clr  = 1'b1;
              state_next   = S_T_RD;
            end
            FUNC_REG: begin
              if (st.ms_zero || st.full) begin
                rsel_next  = EM_REG_FAIL;
                state_next = S_REPLY;
              end else begin
                cmd.idx_free = 1'b1;
                state_next   = S_MUL;
              end
            end
            FUNC_UNREG: begin
              if (st.tgt_zero) begin
                rsel_next  = EM_UNREG_FAIL;
                state_next = S_REPLY;
              end else begin
                cmd.idx_clr = 1'b1;
                state_next  = S_U_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_next = (st.func_q == FUNC_TICK) ? S_WR_RELOAD : S_WR_NEW;
        end
      end
      S_WR_NEW: begin
        cmd.wr_new = 1'b1;
        rsel_next  = EM_REG_OK;
        state_next = S_REPLY;
      end
      S_WR_RELOAD: begin
        cmd.wr_reload = 1'b1;
        if (st.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_E_SCAN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_T_RD;
        end
      end
      S_T_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_T_EV;
      end
      S_T_EV: begin
        if (st.due) begin
          cmd.set_fired = 1'b1;
        end
        if (st.due && st.periodic) begin
          state_next = S_MUL;
        end else begin
          cmd.clr_active = st.due;
          if (st.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_E_SCAN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_T_RD;
          end
        end
      end
      S_E_SCAN: begin
        if (st.fired) begin
          cmd.mem_rd = 1'b1;
          state_next = S_E_OUT;
        end else if (st.idx_last) begin
          state_next = S_E_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_E_OUT: begin
        cmd.emit_sel = EM_FIRE;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.idx_last) begin
            state_next = S_E_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_E_SCAN;
          end
        end
      end
      S_E_DONE: begin
        cmd.emit_sel = EM_DONE;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_U_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_U_EV;
      end
      S_U_EV: begin
        if (st.match) begin
          cmd.clr_active = 1'b1;
          rsel_next      = EM_UNREG_OK;
          state_next     = S_REPLY;
        end else if (st.idx_last) begin
          rsel_next  = EM_UNREG_FAIL;
          state_next = S_REPLY;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_U_RD;
        end
      end
      S_REPLY: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/sttbl_dp.sv
// ----------------------------------------------------------------------------
// sttbl_dp
// Slot storage, tick counter, interval scaling and result register.
// ----------------------------------------------------------------------------
module sttbl_dp
  import sttbl_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output st_t         st,
  input  logic [20:0] tick_rate_hz,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_span_ms,
  input  logic        in_periodic,
  input  logic [31:0] in_target_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_timer_ident,
  output logic [3:0]  out_slot_index,
  output logic        out_success,
  output logic [4:0]  out_live_count,
  output logic [63:0] out_tick_now,
  output logic        out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [63:0]        tick_counter;
  logic [31:0]        next_ident;
  logic [CW-1:0]      active_total;
  logic [SLOTS-1:0]   active;
  logic [SLOTS-1:0]   fired;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      free_idx;
  func_t              func_q;
  logic [31:0]        ms_q;
  logic               per_q;
  logic [31:0]        tgt_q;
  logic [31:0]        rep_id;

  logic [31:0]        mem_ident [SLOTS];
  logic [63:0]        mem_dl [SLOTS];
  logic [31:0]        mem_iv [SLOTS];
  logic               mem_per [SLOTS];
  logic [31:0]        rd_ident;
  logic [63:0]        rd_dl;
  logic [31:0]        rd_iv;
  logic               rd_per;

  logic [63:0]        dq;
  logic [DivCntW-1:0] div_cnt;
  logic [31:0]        sc_src;
  logic [31:0]        sc_q;
  logic [63:0]        sc_acc;
  logic [63:0]        sc_prod;
  logic [31:0]        mul_src;
  logic [63:0]        deadline;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign mul_src  = (func_q == FUNC_TICK) ? rd_iv : ms_q;
  assign deadline = tick_counter + dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      next_ident   <= 32'd1;
      active_total <= '0;
      active       <= '0;
      fired        <= '0;
      div_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.latch) begin
        fired <= '0;
      end
      if (cmd.tick_inc) begin
        tick_counter <= tick_counter + 64'd1;
      end
      if (cmd.mul_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DivCntW'(1);
      end
      if (cmd.wr_new) begin
        active[idx]  <= 1'b1;
        active_total <= active_total + CW'(1);
        next_ident   <= (next_ident == 32'hFFFF_FFFF) ? 32'd1 : next_ident + 32'd1;
      end
      if (cmd.clr_active) begin
        active[idx]  <= 1'b0;
        active_total <= active_total - CW'(1);
      end
      if (cmd.set_fired) begin
        fired[idx] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ms * rate / 1000 as q * rate + (r * rate) / 1000 with ms = 1000 * q + r
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      sc_src  <= mul_src;
      sc_prod <= 64'(mul_src) * 64'(Recip1000);
    end else if (cmd.div_step) begin
      case (div_cnt)
        SC_QUOT: begin
          sc_q <= 32'(sc_prod >> RecipShift);
        end
        SC_SPLIT: begin
          sc_acc <= 64'(sc_q) * 64'(tick_rate_hz);
          sc_src <= sc_src - sc_q * 32'(MsPerSec);
        end
        SC_REM: begin
          sc_prod <= 64'(sc_src) * 64'(tick_rate_hz);
        end
        SC_RECIP: begin
          sc_prod <= 64'(sc_prod[31:0]) * 64'(Recip1000);
        end
        default: begin
          dq <= sc_acc + (sc_prod >> RecipShift);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func_t'(in_func);
      ms_q   <= in_span_ms;
      per_q  <= in_periodic;
      tgt_q  <= in_target_id;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_free) begin
      idx <= free_idx;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
    if (cmd.wr_new) begin
      rep_id <= next_ident;
    end
    if (cmd.mem_rd) begin
      rd_ident <= mem_ident[idx];
      rd_dl    <= mem_dl[idx];
      rd_iv    <= mem_iv[idx];
      rd_per   <= mem_per[idx];
    end
    if (cmd.wr_new) begin
      mem_ident[idx] <= next_ident;
      mem_iv[idx]    <= ms_q;
      mem_per[idx]   <= per_q;
    end
    if (cmd.wr_new || cmd.wr_reload) begin
      mem_dl[idx] <= deadline;
    end
    if (cmd.out_load) begin
      out_live_count <= 5'(active_total);
      out_tick_now   <= tick_counter;
      out_last       <= 1'b1;
      out_success    <= 1'b0;
      out_slot_index <= 4'd0;
      out_timer_ident <= 32'd0;
      case (cmd.emit_sel)
        EM_REG_OK: begin
          out_kind        <= KIND_REG;
          out_timer_ident <= rep_id;
          out_slot_index  <= 4'(idx);
          out_success     <= 1'b1;
        end
        EM_REG_FAIL: begin
          out_kind <= KIND_REG;
        end
        EM_UNREG_OK: begin
          out_kind        <= KIND_UNREG;
          out_timer_ident <= tgt_q;
          out_slot_index  <= 4'(idx);
          out_success     <= 1'b1;
        end
        EM_UNREG_FAIL: begin
          out_kind        <= KIND_UNREG;
          out_timer_ident <= tgt_q;
        end
        EM_FIRE: begin
          out_kind        <= KIND_FIRE;
          out_timer_ident <= rd_ident;
          out_slot_index  <= 4'(idx);
          out_last        <= 1'b0;
        end
        default: begin
          out_kind <= KIND_DONE;
        end
      endcase
    end
  end

  assign st.func_in  = func_t'(in_func);
  assign st.func_q   = func_q;
  assign st.ms_zero  = (in_span_ms == 32'd0);
  assign st.tgt_zero = (in_target_id == 32'd0);
  assign st.full     = &active;
  assign st.idx_last = (idx == IW'(SLOTS - 1));
  assign st.due      = active[idx] && (tick_counter >= rd_dl);
  assign st.match    = active[idx] && (rd_ident == tgt_q);
  assign st.periodic = rd_per;
  assign st.fired    = fired[idx];
  assign st.div_done = (div_cnt == DivCntW'(DivCycles - 1));
  assign st.out_free = !out_valid || out_ready;

endmodule

FILE: hw/rtl/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table
// Table of one-shot and periodic timers with an APB tick-rate register.
// ----------------------------------------------------------------------------
// Register: transfer in, rate/1000 scaling, a slot write, the result load; a rejected
// register or unregister goes straight to the result load. Unregister reads the slots
// in turn until one matches. Tick: each slot is read and checked, a due periodic timer
// is rescaled and reloaded; a second scan emits the fire results and the closing result.
// One item in flight; the next item is taken while the last result waits.
// Synchronous reset: counter 0, next id 1, all slots free, rate 100.
module software_timer_table
  import sttbl_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  sttbl_in_if.sink    in_ch,
  sttbl_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [20:0] tick_rate_hz;
  cmd_t        cmd;
  st_t         st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_hz <= 21'd100;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TICK_RATE)) begin
      tick_rate_hz <= pwdata[20:0];
    end
  end

  assign prdata = (paddr[2] == REG_TICK_RATE) ? {11'd0, tick_rate_hz} : 32'd0;

  sttbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  sttbl_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .tick_rate_hz    (tick_rate_hz),
    .in_func         (in_ch.func),
    .in_span_ms      (in_ch.span_ms),
    .in_periodic     (in_ch.periodic),
    .in_target_id    (in_ch.target_id),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_timer_ident (out_ch.timer_ident),
    .out_slot_index  (out_ch.slot_index),
    .out_success     (out_ch.success),
    .out_live_count  (out_ch.live_count),
    .out_tick_now    (out_ch.tick_now),
    .out_last        (out_ch.last)
  );

endmodule

FILE: hw/rtl/sttbl_checker.sv
// ----------------------------------------------------------------------------
// sttbl_checker
// Port-level checks on the timer table result channel.
// ----------------------------------------------------------------------------
module sttbl_checker
  import sttbl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [31:0] timer_ident,
  input logic        success,
  input logic        last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DONE) |-> last && !success)
    else $error("tick done must close the step");

  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FIRE) |-> !last && !success)
    else $error("fire result flagged last or success");

  a_reg_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REG) |-> (success == (timer_ident != 32'd0)))
    else $error("register reply id and success disagree");

endmodule

bind software_timer_table sttbl_checker u_sttbl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .timer_ident (out_ch.timer_ident),
  .success     (out_ch.success),
  .last        (out_ch.last)
);

FILE: bench/software_timer_table_tb.sv
// ----------------------------------------------------------------------------
// software_timer_table_tb
// Self-checking bench for the timer table. A directed table covers reset
// values, zero intervals, a full table and cancels; random tick, register
// and unregister traffic follows under several tick rates and their extremes.
// A predictor of the slot table supplies the expected results, and both
// channels idle at random.
// ----------------------------------------------------------------------------
module software_timer_table_tb;
  import sttbl_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ident;
    logic [3:0]  slot;
    logic        ok;
    logic [4:0]  live;
    logic [63:0] now;
    logic        last;
  } reply_t;

  typedef struct {
    func_t       fn;
    logic [31:0] ms;
    logic        per;
    logic [31:0] tgt;
    logic        chk;
    reply_t      exp;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  sttbl_in_if  in_ch();
  sttbl_out_if out_ch();

  software_timer_table dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // predictor state
  logic [20:0] rate_hz;
  logic [63:0] ticks;
  logic [31:0] fresh_id;
  logic [4:0]  live_timers;
  logic        t_on   [16];
  logic [31:0] t_id   [16];
  logic [63:0] t_due  [16];
  logic [31:0] t_ms   [16];
  logic        t_per  [16];

  reply_t pending_replies[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     n_items = 0, n_replies = 0, n_fires = 0;
  logic   directed_chk = 0;
  reply_t directed_exp;

  function automatic logic [63:0] ms_to_ticks(logic [31:0] ms);
    logic [63:0] prod;
    prod = 64'(ms) * 64'(rate_hz);
    return prod / 64'd1000;
  endfunction

  function automatic reply_t mk(logic [1:0] k, logic [31:0] id, logic [3:0] s,
                                logic ok, logic l);
    reply_t r;
    r.kind = k; r.ident = id; r.slot = s; r.ok = ok;
    r.live = 0; r.now = 0; r.last = l;
    return r;
  endfunction

  task automatic predict_step(func_t fn, logic [31:0] ms, logic per, logic [31:0] tgt);
    reply_t outq[$];
    reply_t r;
    bit done;
    done = 0;
    case (fn)
      FUNC_TICK: begin
        ticks++;
        for (int i = 0; i < 16; i++) begin
          if (t_on[i] && ticks >= t_due[i]) begin
            outq.push_back(mk(KIND_FIRE, t_id[i], 4'(i), 0, 0));
            if (t_per[i]) t_due[i] = ticks + ms_to_ticks(t_ms[i]);
            else begin
              t_on[i] = 0;
              live_timers--;
            end
          end
        end
        outq.push_back(mk(KIND_DONE, 0, 0, 0, 1));
      end
      FUNC_REG: begin
        if (ms != 0)
          for (int i = 0; i < 16 && !done; i++) begin
            if (!t_on[i]) begin
              t_id[i] = fresh_id;
              fresh_id++;
              if (fresh_id == 0) fresh_id = 1;
              t_due[i] = ticks + ms_to_ticks(ms);
              t_ms[i] = ms;
              t_per[i] = per;
              t_on[i] = 1;
              live_timers++;
              outq.push_back(mk(KIND_REG, t_id[i], 4'(i), 1, 1));
              done = 1;
            end
          end
        if (!done) outq.push_back(mk(KIND_REG, 0, 0, 0, 1));
      end
      FUNC_UNREG: begin
        if (tgt != 0)
          for (int i = 0; i < 16 && !done; i++) begin
            if (t_on[i] && t_id[i] == tgt) begin
              t_on[i] = 0;
              live_timers--;
              outq.push_back(mk(KIND_UNREG, tgt, 4'(i), 1, 1));
              done = 1;
            end
          end
        if (!done) outq.push_back(mk(KIND_UNREG, tgt, 0, 0, 1));
      end
      default: ;
    endcase
    foreach (outq[k]) begin
      r = outq[k];
      r.live = live_timers;
      r.now = ticks;
      pending_replies.push_back(r);
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    rate_hz = data[20:0];
  endtask

  task automatic drain();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic send(func_t fn, logic [31:0] ms, logic per, logic [31:0] tgt);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    repeat (gap) @(negedge clk);
    @(negedge clk);
    in_ch.valid <= 1;
    in_ch.func <= fn; in_ch.span_ms <= ms;
    in_ch.periodic <= per; in_ch.target_id <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_step(fn, ms, per, tgt);
    n_items++;
    @(negedge clk);
    in_ch.valid <= 0;
  endtask

  // receiver
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 2) == 0) ? 1'b1 : 1'b0;
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(0, 18)) @(negedge clk);
        out_ch.ready <= 1;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    reply_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.kind; got.ident = out_ch.timer_ident;
      got.slot = out_ch.slot_index; got.ok = out_ch.success;
      got.live = out_ch.live_count; got.now = out_ch.tick_now;
      got.last = out_ch.last;
      n_replies++;
      if (got.kind == KIND_FIRE) n_fires++;
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual %p", $time, got);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, got);
          errors++;
        end
      end
      if (directed_chk && got.last) begin
        directed_chk = 0;
        if (got !== directed_exp) begin
          $display("%0t table mismatch: expected %p actual %p", $time,
                   directed_exp, got);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic row_t row(func_t fn, logic [31:0] ms, logic per, logic [31:0] tgt,
                               logic chk, reply_t e);
    row_t r;
    r.fn = fn; r.ms = ms; r.per = per; r.tgt = tgt; r.chk = chk; r.exp = e;
    return r;
  endfunction

  function automatic reply_t ex(logic [1:0] k, logic [31:0] id, logic [3:0] s, logic ok,
                                logic [4:0] l, logic [63:0] n);
    reply_t r;
    r = mk(k, id, s, ok, 1);
    r.live = l; r.now = n;
    return r;
  endfunction

  initial begin
    row_t plan[$];
    logic [31:0] ids[$];
    int j;
    func_t fn;
    logic [31:0] ms;

    in_ch.valid = 0; in_ch.func = FUNC_TICK; in_ch.span_ms = 0;
    in_ch.periodic = 0; in_ch.target_id = 0;
    rate_hz = 100; ticks = 0; fresh_id = 1; live_timers = 0;
    for (int i = 0; i < 16; i++) t_on[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    plan.push_back(row(FUNC_TICK, 0, 0, 0, 1, ex(KIND_DONE, 0, 0, 0, 0, 1)));
    plan.push_back(row(FUNC_REG, 0, 1, 0, 1, ex(KIND_REG, 0, 0, 0, 0, 1)));
    plan.push_back(row(FUNC_UNREG, 0, 0, 0, 1, ex(KIND_UNREG, 0, 0, 0, 0, 1)));
    plan.push_back(row(FUNC_UNREG, 0, 0, 32'hFFFF_FFFF, 1,
                       ex(KIND_UNREG, 32'hFFFF_FFFF, 0, 0, 0, 1)));
    plan.push_back(row(FUNC_REG, 10, 1, 0, 1, ex(KIND_REG, 1, 0, 1, 1, 1)));
    plan.push_back(row(FUNC_REG, 32'hFFFF_FFFF, 0, 0, 1, ex(KIND_REG, 2, 1, 1, 2, 1)));
    plan.push_back(row(FUNC_REG, 30, 0, 0, 0, '0));
    plan.push_back(row(FUNC_NONE, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, '0));
    plan.push_back(row(FUNC_TICK, 0, 0, 0, 0, '0));
    plan.push_back(row(FUNC_TICK, 0, 0, 0, 0, '0));
    plan.push_back(row(FUNC_TICK, 0, 0, 0, 0, '0));
    plan.push_back(row(FUNC_UNREG, 0, 1, 2, 1, ex(KIND_UNREG, 2, 1, 1, 1, 4)));
    for (int i = 0; i < 14; i++)
      plan.push_back(row(FUNC_REG, 32'h5555_0000 + i, i[0], 0, 0, '0));
    plan.push_back(row(FUNC_REG, 1, 1, 0, 0, '0));
    foreach (plan[k]) begin
      if (plan[k].chk) begin
        while (pending_replies.size() != 0) @(posedge clk);
        directed_exp = plan[k].exp;
        directed_chk = 1;
      end
      send(plan[k].fn, plan[k].ms, plan[k].per, plan[k].tgt);
      if (plan[k].chk) while (directed_chk) @(posedge clk);
    end
    // table full now: one more register must fail
    send(FUNC_REG, 5, 0, 0);
    drain();

    // rate extremes, then random traffic; zero rate yields zero-tick periods
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: apb_write(3'd0, 32'd19);
        1: apb_write(3'd0, 32'd1193182);
        2: apb_write(3'd0, 32'd0);
        3: apb_write(3'd0, 32'h001F_FFFF);
        default: apb_write(3'd0, 32'd100);
      endcase
      for (int k = 0; k < 24; k++) begin
        j = $urandom_range(0, 19);
        if (j < 8) fn = FUNC_TICK;
        else if (j < 13) fn = FUNC_REG;
        else if (j < 18) fn = FUNC_UNREG;
        else fn = FUNC_NONE;
        ms = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 60);
        if (fn == FUNC_UNREG && ids.size() != 0 && $urandom_range(0, 3) != 0)
          send(fn, ms, $urandom_range(0, 1), ids[$urandom_range(0, ids.size() - 1)]);
        else
          send(fn, ms, $urandom_range(0, 1), $urandom_range(0, 3) == 0 ? $urandom :
               $urandom_range(0, 40));
        ids.delete();
        for (int i = 0; i < 16; i++) if (t_on[i]) ids.push_back(t_id[i]);
        if (k == 12) while (pending_replies.size() != 0) @(posedge clk);
      end
      drain();
    end

    $display("Run covered %0d items and %0d result transfers, %0d timer fires,",
             n_items, n_replies, n_fires);
    $display("under five tick-rate settings including zero and the 21-bit maximum.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/sttbl_pkg.sv
hw/rtl/sttbl_if.sv
hw/rtl/sttbl_ctrl.sv
hw/rtl/sttbl_dp.sv
hw/rtl/software_timer_table.sv
hw/rtl/sttbl_checker.sv
bench/software_timer_table_tb.sv
